// ----- rtl/core/ipv4_hc_pkg.sv -----
// ----------------------------------------------------------------------------
// IPv4 header check package
// Request and result types, reject codes and header constants shared by the
// header check block and its checker.
// ----------------------------------------------------------------------------
`default_nettype none

package ipv4_hc_pkg;

  // Reject codes, first failing check wins
  localparam logic [2:0] REJ_OK        = 3'd0;
  localparam logic [2:0] REJ_SHORT_LEN = 3'd1;
  localparam logic [2:0] REJ_CHECKSUM  = 3'd2;
  localparam logic [2:0] REJ_VERSION   = 3'd3;
  localparam logic [2:0] REJ_OPTIONS   = 3'd4;
  localparam logic [2:0] REJ_IHL_SHORT = 3'd5;

  // Header constants
  localparam logic [15:0] MIN_TOTAL_LEN = 16'd20;
  localparam logic [3:0]  IP_VERSION    = 4'd4;
  localparam logic [3:0]  BASE_IHL      = 4'd5;
  localparam logic [15:0] CSUM_RECOMP   = 16'hffff;
  localparam logic [15:0] TTL_CSUM_INC  = 16'h0100;

  typedef struct packed {
    logic [7:0]  ver_ihl;
    logic [7:0]  type_of_service;
    logic [15:0] dgram_len;
    logic [15:0] ident;
    logic [15:0] frag_word;
    logic [7:0]  ttl_in;
    logic [7:0]  protocol;
    logic [15:0] checksum_in;
    logic [31:0] src_ip;
    logic [31:0] dst_ip;
    logic [47:0] new_src_mac;
    logic [47:0] new_dst_mac;
  } hc_req_t;

  typedef struct packed {
    logic        header_ok;
    logic [2:0]  reject_code;
    logic [7:0]  ttl_out;
    logic [15:0] checksum_out;
    logic [47:0] src_mac_out;
    logic [47:0] dst_mac_out;
  } hc_res_t;

endpackage

`default_nettype wire

// ----- rtl/core/ipv4_header_check_ttl_rewrite.sv -----
// ----------------------------------------------------------------------------
// IPv4 header check and TTL rewrite
// Pipeline: a taken request passes the input register, then the result
// register, before its result strobe. Throughput: one request
// per cycle; busy stays low, since the combinational checksum logic never stalls.
// Reset (rst, synchronous) drops any request in flight and clears done.
// ----------------------------------------------------------------------------
`default_nettype none

module ipv4_header_check_ttl_rewrite
  import ipv4_hc_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    start,
  output logic         busy,
  input  wire hc_req_t hdr,
  output logic         done,
  output hc_res_t      res
);

  // Ones' complement fold of a sum of up to sixteen 16-bit words
  function automatic logic [15:0] fold16(input logic [19:0] s);
    logic [16:0] s1;
    logic [16:0] s2;
    begin
      s1 = {1'b0, s[15:0]} + {13'd0, s[19:16]};
      s2 = {1'b0, s1[15:0]} + {16'd0, s1[16]};
      fold16 = s2[15:0];
    end
  endfunction

  // Input register
  logic    req_vld;
  hc_req_t req;

  // Result register
  hc_res_t res_next;

  // Checksum sums over the received and decremented TTL
  logic [19:0] base_sum;
  logic [19:0] sum_rx;
  logic [19:0] sum_dec;
  logic [15:0] csum_rx;
  logic [15:0] csum_dec;
  logic [7:0]  ttl_dec;
  logic [16:0] inc_sum;
  logic [15:0] csum_inc;
  logic [2:0]  code;

  assign busy = 1'b0;

  // Capture each request
  always_ff @(posedge clk) begin
    if (rst) begin
      req_vld <= 1'b0;
    end else begin
      req_vld <= start & ~busy;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      req <= hdr;
    end
  end

  // Sum the header words, TTL/protocol and checksum words excluded
  always_comb begin
    base_sum = {4'd0, req.ver_ihl, req.type_of_service}
             + {4'd0, req.dgram_len}
             + {4'd0, req.ident}
             + {4'd0, req.frag_word}
             + {4'd0, req.src_ip[31:16]}
             + {4'd0, req.src_ip[15:0]}
             + {4'd0, req.dst_ip[31:16]}
             + {4'd0, req.dst_ip[15:0]};
    ttl_dec  = req.ttl_in - 8'd1;
    sum_rx   = base_sum + {4'd0, req.ttl_in, req.protocol};
    sum_dec  = base_sum + {4'd0, ttl_dec, req.protocol};
    csum_rx  = ~fold16(sum_rx);
    csum_dec = ~fold16(sum_dec);
    inc_sum  = {1'b0, req.checksum_in} + {1'b0, TTL_CSUM_INC};
    csum_inc = inc_sum[15:0] + {15'd0, inc_sum[16]};
  end

  // Run the checks in priority order
  always_comb begin
    if (req.dgram_len < MIN_TOTAL_LEN) begin
      code = REJ_SHORT_LEN;
    end else if (csum_rx != req.checksum_in) begin
      code = REJ_CHECKSUM;
    end else if (req.ver_ihl[7:4] != IP_VERSION) begin
      code = REJ_VERSION;
    end else if (req.ver_ihl[3:0] > BASE_IHL) begin
      code = REJ_OPTIONS;
    end else if (req.ver_ihl[3:0] < BASE_IHL) begin
      code = REJ_IHL_SHORT;
    end else begin
      code = REJ_OK;
    end
  end

  // Build the rewritten header fields
  always_comb begin
    res_next.header_ok    = (code == REJ_OK);
    res_next.reject_code  = code;
    res_next.ttl_out      = req.ttl_in;
    res_next.checksum_out = req.checksum_in;
    res_next.src_mac_out  = '0;
    res_next.dst_mac_out  = '0;
    if (code == REJ_OK) begin
      res_next.src_mac_out = req.new_src_mac;
      res_next.dst_mac_out = req.new_dst_mac;
      if (req.ttl_in != 8'd0) begin
        res_next.ttl_out = ttl_dec;
        if (req.checksum_in == CSUM_RECOMP) begin
          res_next.checksum_out = csum_dec;
        end else begin
          res_next.checksum_out = csum_inc;
        end
      end
    end
  end

  // Register the result and its strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= req_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (req_vld) begin
      res <= res_next;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/ipv4_hc_checker.sv -----
// ----------------------------------------------------------------------------
// IPv4 header check port checker
// Watches the request and result ports of the header check block and flags
// lost or spurious results, bad reject coding, and MAC leaks or TTL changes on rejected headers.
// ----------------------------------------------------------------------------
`default_nettype none

module ipv4_hc_checker
  import ipv4_hc_pkg::*;
(
  input wire logic    clk,
  input wire logic    rst,
  input wire logic    start,
  input wire logic    busy,
  input wire hc_req_t hdr,
  input wire logic    done,
  input wire hc_res_t res
);

  // Every request gives a result after the input and result registers
  a_req_to_done: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##2 done)
    else $error("request without result");

  // No result without a request taken through the input register
  a_done_has_req: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(start, 2) && !$past(busy, 2)))
    else $error("result without request");

  // OK flag agrees with the reject code
  a_ok_code: assert property (@(posedge clk) disable iff (rst)
    done |-> (res.header_ok == (res.reject_code == REJ_OK)))
    else $error("header_ok disagrees with reject_code");

  // Rejected headers keep TTL and carry no MAC addresses
  a_reject_clean: assert property (@(posedge clk) disable iff (rst)
    (done && !res.header_ok) |->
      (res.src_mac_out == '0 && res.dst_mac_out == '0 &&
       res.ttl_out == $past(hdr.ttl_in, 2)))
    else $error("rejected header altered");

endmodule

bind ipv4_header_check_ttl_rewrite ipv4_hc_checker u_ipv4_hc_checker (.*);

`default_nettype wire
